FILE: src/bpc_pkg.sv
// Package for the button press classifier: event codes, register map and config type.
package bpc_pkg;

   // Event codes carried on the result channel.
   localparam logic [1:0] EV_NONE   = 2'd0;
   localparam logic [1:0] EV_SHORT  = 2'd1;
   localparam logic [1:0] EV_LONG   = 2'd2;
   localparam logic [1:0] EV_DOUBLE = 2'd3;

   // Register indexes on the configuration port.
   localparam logic [1:0] REG_DEBOUNCE = 2'd0;
   localparam logic [1:0] REG_LONG     = 2'd1;
   localparam logic [1:0] REG_DOUBLE   = 2'd2;
   localparam logic [1:0] REG_MASK     = 2'd3;

   // Reset values of the registers.
   localparam logic [15:0] DEBOUNCE_RESET = 16'd40;
   localparam logic [15:0] LONG_RESET     = 16'd1500;
   localparam logic [15:0] DOUBLE_RESET   = 16'd400;
   localparam logic [7:0]  MASK_RESET     = 8'hFF;

   // Press tally saturates here.
   localparam logic [1:0] TALLY_MAX = 2'd3;
   localparam logic [1:0] TALLY_DOUBLE = 2'd2;

   // Configuration handed from the register file to the classifier.
   typedef struct packed {
      logic [15:0] debounce_time;
      logic [15:0] long_press_time;
      logic [15:0] double_press_window;
      logic [7:0]  supported_mask;
   } cfg_type;

endpackage

FILE: src/bpc_engine.sv
// Debounce and press classification state with its next-state logic.
module bpc_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  bpc_pkg::cfg_type     cfg,
   input  logic [7:0]           present_mask,
   input  logic                 sample_valid,
   input  logic [7:0]           button_bits,
   input  logic [31:0]          now_time,
   output logic [1:0]           press_event
);
   import bpc_pkg::*;

   logic        raw_level_ff, raw_level_in;
   logic [31:0] raw_change_time_ff, raw_change_time_in;
   logic        stable_level_ff, stable_level_in;
   logic [31:0] press_start_time_ff, press_start_time_in;
   logic [1:0]  press_tally_ff, press_tally_in;
   logic [31:0] last_release_time_ff, last_release_time_in;

   logic        raw;
   logic        settled;
   logic [31:0] held;
   logic [31:0] since_release;

   // Raw level, debounce timer and classification of an accepted edge.
   always_comb begin
      raw = sample_valid && ((button_bits & present_mask & cfg.supported_mask) != 8'd0);
      raw_level_in = raw;
      raw_change_time_in = (raw != raw_level_ff) ? now_time : raw_change_time_ff;
      settled = ((now_time - raw_change_time_in) >= {16'd0, cfg.debounce_time});
      held = now_time - press_start_time_ff;
      since_release = now_time - last_release_time_ff;
      stable_level_in = stable_level_ff;
      press_start_time_in = press_start_time_ff;
      press_tally_in = press_tally_ff;
      last_release_time_in = last_release_time_ff;
      press_event = EV_NONE;
      if (settled && (raw != stable_level_ff)) begin
         stable_level_in = raw;
         if (raw) begin
            press_start_time_in = now_time;
            if (press_tally_ff != TALLY_MAX) begin
               press_tally_in = press_tally_ff + 2'd1;
            end
         end else begin
            last_release_time_in = now_time;
            priority if (held >= {16'd0, cfg.long_press_time}) begin
               press_event = EV_LONG;
               press_tally_in = 2'd0;
            end else if ((last_release_time_ff != 32'd0) &&
                         (since_release <= {16'd0, cfg.double_press_window}) &&
                         (press_tally_ff >= TALLY_DOUBLE)) begin
               press_event = EV_DOUBLE;
               press_tally_in = 2'd0;
            end else begin
               press_event = EV_SHORT;
            end
         end
      end
   end

   // State advances only when an item leaves the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_level_ff <= 1'b0;
         raw_change_time_ff <= 32'd0;
         stable_level_ff <= 1'b0;
         press_start_time_ff <= 32'd0;
         press_tally_ff <= 2'd0;
         last_release_time_ff <= 32'd0;
      end else if (fire) begin
         raw_level_ff <= raw_level_in;
         raw_change_time_ff <= raw_change_time_in;
         stable_level_ff <= stable_level_in;
         press_start_time_ff <= press_start_time_in;
         press_tally_ff <= press_tally_in;
         last_release_time_ff <= last_release_time_in;
      end
   end

endmodule

FILE: src/button_press_classifier_core.sv
// Top level of the button press classifier: handshakes, registers and result register.
//
// Each transfer on the req_ channel is one poll of the buttons; each poll yields
// exactly one transfer on the rsp_ channel carrying 0 (none), 1 (short), 2 (long)
// or 3 (double press). A poll is held in the input register, is classified there
// against the debounce state, and moves into the result register once that one is free.
// Its result is then offered from the result register until it transfers. One poll is
// taken every cycle; the only limit is the result register, which holds its transfer
// while rsp_stall is high. Registers on the APB port lie at byte addresses 0, 4, 8 and 12;
// the user must write them only when idle, as the block does not enforce it.
module button_press_classifier_core #(
   parameter int BUTTON_COUNT = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_sample_valid,
   input  logic [7:0]  req_button_bits,
   input  logic [31:0] req_now_time,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_press_event,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import bpc_pkg::*;

   localparam logic [7:0] PRESENT_MASK =
      (BUTTON_COUNT >= 8) ? 8'hFF : 8'((9'd1 << BUTTON_COUNT) - 9'd1);

   cfg_type     cfg_ff;
   logic        cfg_write;
   logic [1:0]  reg_index;

   logic        in_valid_ff, in_valid_in;
   logic        in_sample_valid_ff;
   logic [7:0]  in_button_bits_ff;
   logic [31:0] in_now_time_ff;
   logic        out_valid_ff, out_valid_in;
   logic [1:0]  out_event_ff;
   logic        out_free;
   logic        in_move;
   logic        req_take;
   logic [1:0]  event_code;

   // Register file on the APB port.
   assign pready = 1'b1;
   assign reg_index = paddr[3:2];
   assign cfg_write = psel && penable && pwrite && pready;

   always_comb begin
      unique case (reg_index)
         REG_DEBOUNCE: prdata = {16'd0, cfg_ff.debounce_time};
         REG_LONG:     prdata = {16'd0, cfg_ff.long_press_time};
         REG_DOUBLE:   prdata = {16'd0, cfg_ff.double_press_window};
         REG_MASK:     prdata = {24'd0, cfg_ff.supported_mask};
         default:      prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_time <= DEBOUNCE_RESET;
         cfg_ff.long_press_time <= LONG_RESET;
         cfg_ff.double_press_window <= DOUBLE_RESET;
         cfg_ff.supported_mask <= MASK_RESET;
      end else if (cfg_write) begin
         unique case (reg_index)
            REG_DEBOUNCE: cfg_ff.debounce_time <= pwdata[15:0];
            REG_LONG:     cfg_ff.long_press_time <= pwdata[15:0];
            REG_DOUBLE:   cfg_ff.double_press_window <= pwdata[15:0];
            REG_MASK:     cfg_ff.supported_mask <= pwdata[7:0];
            default:      ;
         endcase
      end
   end

   // Pipeline flow control: the input register moves when the result register frees.
   assign out_free = !out_valid_ff || !rsp_stall;
   assign in_move = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take = req_valid && !req_stall;
   assign in_valid_in = req_take || (in_valid_ff && !in_move);
   assign out_valid_in = in_move || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers capture on each transfer.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_sample_valid_ff <= req_sample_valid;
         in_button_bits_ff <= req_button_bits;
         in_now_time_ff <= req_now_time;
      end
      if (in_move) begin
         out_event_ff <= event_code;
      end
   end

   // Classifier between the input register and the result register.
   bpc_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .fire         (in_move),
      .cfg          (cfg_ff),
      .present_mask (PRESENT_MASK),
      .sample_valid (in_sample_valid_ff),
      .button_bits  (in_button_bits_ff),
      .now_time     (in_now_time_ff),
      .press_event  (event_code)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_press_event = out_event_ff;

   // An item leaving the input register is always offered at the output next.
   a_move_to_out: assert property (@(posedge clock) disable iff (reset)
      in_move |=> rsp_valid)
      else $error("item left input register without reaching the result register");

   // The input side stalls only when both registers are full and the output waits.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid && rsp_stall))
      else $error("input stalled without a full pipeline");

   // A debounce write lands in the register.
   a_cfg_write: assert property (@(posedge clock) disable iff (reset)
      (cfg_write && (reg_index == REG_DEBOUNCE)) |=>
      (cfg_ff.debounce_time == $past(pwdata[15:0])))
      else $error("debounce register write lost");

endmodule
